// ===== rtl/cpx_pkg.sv =====
// Shared types, command and error codes, and the diagonal order table.
package cpx_pkg;

    localparam int MAP_W     = 64;
    localparam int MAP_IDX_W = 6;

    localparam logic [1:0] CMD_SET    = 2'd0;
    localparam logic [1:0] CMD_RESET  = 2'd1;
    localparam logic [1:0] CMD_STATUS = 2'd2;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_ARG   = 2'd1;
    localparam logic [1:0] ERR_FIXED = 2'd2;

    localparam logic [1:0] SRC_IN   = 2'd0;
    localparam logic [1:0] SRC_SCAN = 2'd1;
    localparam logic [1:0] SRC_DIAG = 2'd2;

    localparam logic [3:0] GUARD_LINES = 4'd4;

    typedef struct packed {
        logic       load_in;
        logic       emit;
        logic       last;
        logic [1:0] src;
        logic       scan_step;
        logic       diag_step;
    } t_ctrl_cmd;

    typedef struct packed {
        logic fixed_reset;
        logic cell_hit;
        logic scan_done;
        logic diag_done;
        logic out_free;
    } t_dp_status;

    function automatic logic [1:0] diag_line(input logic [1:0] i);
        logic [1:0] d;
        case (i)
            2'd0: d = 2'd2;
            2'd1: d = 2'd1;
            2'd2: d = 2'd0;
            2'd3: d = 2'd3;
            default: d = 2'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/cpx_ctrl.sv =====
// Controller state machine that sequences requests through the datapath.
module cpx_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  cpx_pkg::t_dp_status   i_status,
    output cpx_pkg::t_ctrl_cmd    o_cmd
);
    import cpx_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DIAG = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.src = SRC_IN;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_status.fixed_reset) begin
                    n_state = S_SCAN;
                end else if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.src = SRC_SCAN;
                if (!i_status.cell_hit || i_status.out_free) begin
                    o_cmd.emit      = i_status.cell_hit;
                    o_cmd.scan_step = 1'b1;
                    if (i_status.scan_done) begin
                        n_state = S_DIAG;
                    end
                end
            end
            S_DIAG: begin
                o_cmd.src = SRC_DIAG;
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.last      = i_status.diag_done;
                    o_cmd.diag_step = 1'b1;
                    if (i_status.diag_done) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== rtl/cpx_datapath.sv =====
// Datapath: request latch, scan counters, switch map, set logic and result register.
module cpx_datapath #(
    parameter int X_LINES = 8,
    parameter int Y_LINES = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_wdata,
    input  logic [1:0]            i_cmd,
    input  logic [3:0]            i_col,
    input  logic [3:0]            i_row,
    input  logic                  i_close_switch,
    input  cpx_pkg::t_ctrl_cmd    i_ctrl,
    output cpx_pkg::t_dp_status   o_status,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic                  o_frame_valid,
    output logic                  o_reset_pulse,
    output logic [6:0]            o_chip_address,
    output logic                  o_data_bit,
    output logic [1:0]            o_error_code,
    output logic [63:0]           o_status_map,
    output logic                  o_last
);
    import cpx_pkg::*;

    localparam int XW = (X_LINES > 1) ? $clog2(X_LINES) : 1;
    localparam int YW = (Y_LINES > 1) ? $clog2(Y_LINES) : 1;

    logic             r_mode;
    logic [MAP_W-1:0] r_map;
    logic [1:0]       r_cmd;
    logic [3:0]       r_col;
    logic [3:0]       r_row;
    logic             r_close;
    logic [XW-1:0]    r_sx;
    logic [YW-1:0]    r_sy;
    logic [1:0]       r_dcnt;

    logic             r_out_valid;
    logic             r_out_frame;
    logic             r_out_pulse;
    logic [6:0]       r_out_addr;
    logic             r_out_data;
    logic [1:0]       r_out_err;
    logic [MAP_W-1:0] r_out_map;
    logic             r_out_last;

    logic [3:0]           sx;
    logic [3:0]           sy;
    logic                 sc;
    logic [MAP_IDX_W-1:0] set_idx;
    logic [MAP_IDX_W-1:0] scan_idx;
    logic             forbid;
    logic             range_bad;
    logic             set_ok;
    logic             x_hi;
    logic [3:0]       x_lo;
    logic [6:0]       set_addr;

    logic             res_frame;
    logic             res_pulse;
    logic [6:0]       res_addr;
    logic             res_data;
    logic [1:0]       res_err;
    logic [MAP_W-1:0] n_map;

    always_comb begin
        case (i_ctrl.src)
            SRC_SCAN: begin
                sx = 4'(r_sx);
                sy = 4'(r_sy);
                sc = 1'b0;
            end
            SRC_DIAG: begin
                sx = {2'b00, diag_line(r_dcnt)};
                sy = {2'b00, diag_line(r_dcnt)};
                sc = 1'b1;
            end
            default: begin
                sx = r_col;
                sy = r_row;
                sc = r_close;
            end
        endcase
    end

    assign forbid = r_mode && (sx < GUARD_LINES) &&
                    (((sx == sy) && !sc) || ((sx != sy) && sc));
    assign range_bad = (sx >= 4'(X_LINES)) || (sy >= 4'(Y_LINES));
    assign set_ok    = !forbid && !range_bad;
    assign set_idx   = MAP_IDX_W'(8'(sy) * 8'(X_LINES) + 8'(sx));

    assign x_hi = (sx >= 4'd6);
    assign x_lo = x_hi ? (sx - 4'd6) : sx;
    assign set_addr = (sy < 4'd4) ? {sy[1:0], 1'b0, sx} : {1'b0, x_hi, 2'b11, x_lo[2:0]};

    always_comb begin
        res_frame = 1'b0;
        res_pulse = 1'b0;
        res_addr  = '0;
        res_data  = 1'b0;
        res_err   = ERR_OK;
        n_map     = r_map;
        if (i_ctrl.src != SRC_IN || r_cmd == CMD_SET) begin
            if (forbid) begin
                res_err = ERR_FIXED;
            end else if (range_bad) begin
                res_err = ERR_ARG;
            end else begin
                res_frame = 1'b1;
                res_addr  = set_addr;
                res_data  = sc;
                n_map[set_idx] = sc;
            end
        end else begin
            case (r_cmd)
                CMD_RESET: begin
                    res_pulse = 1'b1;
                    n_map     = '0;
                end
                CMD_STATUS: begin
                    res_err = ERR_OK;
                end
                default: begin
                    res_err = ERR_ARG;
                end
            endcase
        end
    end

    assign scan_idx = MAP_IDX_W'(8'(r_sy) * 8'(X_LINES) + 8'(r_sx));

    assign o_status.fixed_reset = (r_cmd == CMD_RESET) && r_mode;
    assign o_status.cell_hit    = r_map[scan_idx] &&
                                  !((4'(r_sx) < GUARD_LINES) && (4'(r_sx) == 4'(r_sy)));
    assign o_status.scan_done   = (r_sx == XW'(X_LINES - 1)) && (r_sy == YW'(Y_LINES - 1));
    assign o_status.diag_done   = (r_dcnt == 2'd3);
    assign o_status.out_free    = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_map       <= '0;
            r_out_valid <= 1'b0;
            r_sx        <= '0;
            r_sy        <= '0;
            r_dcnt      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (i_ctrl.emit) begin
                r_map       <= n_map;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_ctrl.load_in) begin
                r_sx   <= '0;
                r_sy   <= '0;
                r_dcnt <= '0;
            end else begin
                if (i_ctrl.scan_step) begin
                    if (r_sx == XW'(X_LINES - 1)) begin
                        r_sx <= '0;
                        r_sy <= r_sy + 1'b1;
                    end else begin
                        r_sx <= r_sx + 1'b1;
                    end
                end
                if (i_ctrl.diag_step) begin
                    r_dcnt <= r_dcnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_in) begin
            r_cmd   <= i_cmd;
            r_col   <= i_col;
            r_row   <= i_row;
            r_close <= i_close_switch;
        end
        if (i_ctrl.emit) begin
            r_out_frame <= res_frame;
            r_out_pulse <= res_pulse;
            r_out_addr  <= res_addr;
            r_out_data  <= res_data;
            r_out_err   <= res_err;
            r_out_map   <= n_map;
            r_out_last  <= i_ctrl.last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_valid  = r_out_frame;
    assign o_reset_pulse  = r_out_pulse;
    assign o_chip_address = r_out_addr;
    assign o_data_bit     = r_out_data;
    assign o_error_code   = r_out_err;
    assign o_status_map   = r_out_map;
    assign o_last         = r_out_last;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !i_ctrl.emit)
        else $error("Result register overwritten while stalled.");

    a_pulse_clears_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_pulse) |-> (r_out_map == '0))
        else $error("Reset pulse result carries a nonempty map.");

    a_error_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_err != ERR_OK)) |-> !r_out_frame)
        else $error("Frame sent with an error code.");

    a_load_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.load_in |-> !(i_ctrl.emit || i_ctrl.scan_step || i_ctrl.diag_step))
        else $error("Request loaded while work is in progress.");
`endif

endmodule

// ===== rtl/crosspoint_matrix_controller.sv =====
// Top level of the crosspoint switch matrix controller.
//
//   Channel  Direction  Handshake                Payload
//   in       input      i_in_valid / o_in_stall  i_cmd, i_col, i_row, i_close_switch
//   out      output     o_out_valid / i_out_stall  frame, pulse, address, data, error, map, last
//   cfg      input      i_cfg_we                 i_cfg_wdata
//
// A set, status read or plain reset request is accepted in S_IDLE and then loads its result
// register from S_EXEC. A fixed-mode reset scans the map one crosspoint per cycle, holding on a
// closed cell while the output is stalled, and then closes the four guard diagonal crosspoints.
// An output stall holds the controller until the result register frees up; a new request is
// accepted as soon as the last result is loaded. Reset clears the map and the mode register.
module crosspoint_matrix_controller #(
    parameter int X_LINES = 8,
    parameter int Y_LINES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [3:0]  i_col,
    input  logic [3:0]  i_row,
    input  logic        i_close_switch,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_frame_valid,
    output logic        o_reset_pulse,
    output logic [6:0]  o_chip_address,
    output logic        o_data_bit,
    output logic [1:0]  o_error_code,
    output logic [63:0] o_status_map,
    output logic        o_last
);
    import cpx_pkg::*;

    t_ctrl_cmd  ctrl_cmd;
    t_dp_status dp_status;

    cpx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (ctrl_cmd)
    );

    cpx_datapath #(
        .X_LINES (X_LINES),
        .Y_LINES (Y_LINES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd          (i_cmd),
        .i_col          (i_col),
        .i_row          (i_row),
        .i_close_switch (i_close_switch),
        .i_ctrl         (ctrl_cmd),
        .o_status       (dp_status),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_frame_valid  (o_frame_valid),
        .o_reset_pulse  (o_reset_pulse),
        .o_chip_address (o_chip_address),
        .o_data_bit     (o_data_bit),
        .o_error_code   (o_error_code),
        .o_status_map   (o_status_map),
        .o_last         (o_last)
    );

endmodule

// ===== bench/tb_crosspoint_matrix_controller.sv =====
// Self-checking testbench for the crosspoint matrix controller with a map-tracking scoreboard.
typedef struct packed {
    logic        frame_valid;
    logic        reset_pulse;
    logic [6:0]  chip_address;
    logic        data_bit;
    logic [1:0]  error_code;
    logic [63:0] status_map;
    logic        last;
} t_xp_result;

class t_map_checker #(int X_LINES = 8, int Y_LINES = 8);
    bit [63:0]  switch_map;
    bit         fixed_mode;
    t_xp_result expected_results[$];
    int         errors;

    function new();
        switch_map = '0;
        fixed_mode = 1'b0;
        errors     = 0;
    endfunction

    function int pending();
        return expected_results.size();
    endfunction

    task report(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        errors++;
    endtask

    function bit [6:0] chip_address_of(input int col, input int row);
        int addr;
        if (row < 4) begin
            addr = (row << 5) | col;
        end else begin
            addr = ((col / 6) << 5) | 'h18 | (col % 6);
        end
        return addr[6:0];
    endfunction

    function void push_result(input bit fv, input bit rp, input bit [6:0] addr,
                              input bit data, input logic [1:0] err);
        t_xp_result r;
        r.frame_valid  = fv;
        r.reset_pulse  = rp;
        r.chip_address = addr;
        r.data_bit     = data;
        r.error_code   = err;
        r.status_map   = switch_map;
        r.last         = 1'b0;
        expected_results.push_back(r);
    endfunction

    // The fixed-mode guard is checked before the line range.
    function void predict_set(input int col, input int row, input bit close_sw);
        if (fixed_mode && col < cpx_pkg::GUARD_LINES &&
            ((col == row && !close_sw) || (col != row && close_sw))) begin
            push_result(1'b0, 1'b0, 7'd0, 1'b0, cpx_pkg::ERR_FIXED);
        end else if (col >= X_LINES || row >= Y_LINES) begin
            push_result(1'b0, 1'b0, 7'd0, 1'b0, cpx_pkg::ERR_ARG);
        end else begin
            switch_map[row * X_LINES + col] = close_sw;
            push_result(1'b1, 1'b0, chip_address_of(col, row), close_sw, cpx_pkg::ERR_OK);
        end
    endfunction

    function void note_request(input logic [1:0] cmd, input logic [3:0] col,
                               input logic [3:0] row, input logic close_sw);
        int         diag_seq [4];
        t_xp_result tail;
        diag_seq = '{2, 1, 0, 3};
        case (cmd)
            cpx_pkg::CMD_SET: begin
                predict_set(col, row, close_sw);
            end
            cpx_pkg::CMD_RESET: begin
                if (fixed_mode) begin
                    for (int y = 0; y < Y_LINES; y++) begin
                        for (int x = 0; x < X_LINES; x++) begin
                            if (!(x < cpx_pkg::GUARD_LINES && x == y) &&
                                switch_map[y * X_LINES + x]) begin
                                predict_set(x, y, 1'b0);
                            end
                        end
                    end
                    foreach (diag_seq[i]) begin
                        predict_set(diag_seq[i], diag_seq[i], 1'b1);
                    end
                end else begin
                    switch_map = '0;
                    push_result(1'b0, 1'b1, 7'd0, 1'b0, cpx_pkg::ERR_OK);
                end
            end
            cpx_pkg::CMD_STATUS: begin
                push_result(1'b0, 1'b0, 7'd0, 1'b0, cpx_pkg::ERR_OK);
            end
            default: begin
                push_result(1'b0, 1'b0, 7'd0, 1'b0, cpx_pkg::ERR_ARG);
            end
        endcase
        tail = expected_results.pop_back();
        tail.last = 1'b1;
        expected_results.push_back(tail);
    endfunction

    task check_result(input t_xp_result got);
        t_xp_result want;
        if (expected_results.size() == 0) begin
            report($sformatf("result with nothing expected, map %h", got.status_map));
            return;
        end
        want = expected_results.pop_front();
        if (got.frame_valid !== want.frame_valid)
            report($sformatf("frame_valid %b, expected %b", got.frame_valid, want.frame_valid));
        if (got.reset_pulse !== want.reset_pulse)
            report($sformatf("reset_pulse %b, expected %b", got.reset_pulse, want.reset_pulse));
        if (got.chip_address !== want.chip_address)
            report($sformatf("chip_address %h, expected %h",
                             got.chip_address, want.chip_address));
        if (got.data_bit !== want.data_bit)
            report($sformatf("data_bit %b, expected %b", got.data_bit, want.data_bit));
        if (got.error_code !== want.error_code)
            report($sformatf("error_code %0d, expected %0d", got.error_code, want.error_code));
        if (got.status_map !== want.status_map)
            report($sformatf("status_map %h, expected %h", got.status_map, want.status_map));
        if (got.last !== want.last)
            report($sformatf("last %b, expected %b", got.last, want.last));
    endtask
endclass

module tb_crosspoint_matrix_controller;
    timeunit 1ns;
    timeprecision 1ps;

    import cpx_pkg::*;

    localparam int         X_LINES          = 8;
    localparam int         Y_LINES          = 8;
    localparam logic [1:0] CMD_SPARE        = 2'd3;
    localparam int         SETTLE_CYCLES    = 90;
    localparam int         WATCHDOG_LIMIT   = 4000;
    localparam int         RANDOM_PER_PHASE = 32;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic        i_cfg_wdata    = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [1:0]  i_cmd          = CMD_STATUS;
    logic [3:0]  i_col          = 4'd0;
    logic [3:0]  i_row          = 4'd0;
    logic        i_close_switch = 1'b0;
    logic        i_out_stall    = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_frame_valid;
    logic        o_reset_pulse;
    logic [6:0]  o_chip_address;
    logic        o_data_bit;
    logic [1:0]  o_error_code;
    logic [63:0] o_status_map;
    logic        o_last;

    t_map_checker #(X_LINES, Y_LINES) map_checker;
    int calm_left = 0;

    crosspoint_matrix_controller #(
        .X_LINES(X_LINES),
        .Y_LINES(Y_LINES)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_cmd(i_cmd),
        .i_col(i_col),
        .i_row(i_row),
        .i_close_switch(i_close_switch),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_frame_valid(o_frame_valid),
        .o_reset_pulse(o_reset_pulse),
        .o_chip_address(o_chip_address),
        .o_data_bit(o_data_bit),
        .o_error_code(o_error_code),
        .o_status_map(o_status_map),
        .o_last(o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    task automatic send_request(input logic [1:0] cmd, input logic [3:0] col,
                                input logic [3:0] row, input logic close_sw);
        int gap;
        if (calm_left > 0) begin
            gap = 0;
            calm_left--;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 24) == 0) calm_left = $urandom_range(10, 24);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_cmd          <= cmd;
        i_col          <= col;
        i_row          <= row;
        i_close_switch <= close_sw;
        do @(posedge i_clk); while (o_in_stall);
        map_checker.note_request(cmd, col, row, close_sw);
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (map_checker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic mode);
        wait_for_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        map_checker.fixed_mode = mode;
    endtask

    task automatic random_request();
        int         pick;
        logic [1:0] cmd;
        logic [3:0] col;
        logic [3:0] row;
        logic       close_sw;
        pick     = $urandom_range(0, 99);
        col      = 4'($urandom_range(0, 15));
        row      = 4'($urandom_range(0, 15));
        close_sw = 1'($urandom_range(0, 1));
        if (pick < 70) begin
            cmd = CMD_SET;
            if ($urandom_range(0, 6) != 0) begin
                col = 4'($urandom_range(0, X_LINES - 1));
                row = 4'($urandom_range(0, Y_LINES - 1));
            end
            if (map_checker.fixed_mode && col < GUARD_LINES && $urandom_range(0, 2) != 0) begin
                if ($urandom_range(0, 1) == 1) begin
                    row      = col;
                    close_sw = 1'b1;
                end else begin
                    close_sw = 1'b0;
                end
            end else if (!map_checker.fixed_mode) begin
                close_sw = ($urandom_range(0, 9) < 7);
            end
        end else if (pick < 80) begin
            cmd = CMD_RESET;
        end else if (pick < 93) begin
            cmd = CMD_STATUS;
        end else begin
            cmd = CMD_SPARE;
        end
        send_request(cmd, col, row, close_sw);
    endtask

    initial begin
        map_checker = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(CMD_RESET, 4'd0, 4'd0, 1'b0);
        send_request(CMD_STATUS, 4'd15, 4'd15, 1'b1);
        send_request(CMD_SPARE, 4'd0, 4'd0, 1'b0);
        send_request(CMD_SET, 4'd0, 4'd0, 1'b1);
        send_request(CMD_SET, 4'd7, 4'd7, 1'b1);
        send_request(CMD_SET, 4'd7, 4'd3, 1'b1);
        send_request(CMD_SET, 4'd5, 4'd4, 1'b1);
        send_request(CMD_SET, 4'd6, 4'd5, 1'b1);
        send_request(CMD_SET, 4'd2, 4'd1, 1'b1);
        send_request(CMD_SET, 4'd4, 4'd6, 1'b1);
        send_request(CMD_SET, 4'd7, 4'd7, 1'b0);
        send_request(CMD_SET, 4'd15, 4'd0, 1'b1);
        send_request(CMD_SET, 4'd0, 4'd15, 1'b1);
        send_request(CMD_SET, 4'd8, 4'd8, 1'b0);
        send_request(CMD_SET, 4'd15, 4'd15, 1'b0);

        write_mode(1'b1);
        send_request(CMD_RESET, 4'd0, 4'd0, 1'b0);
        send_request(CMD_SET, 4'd1, 4'd1, 1'b0);
        send_request(CMD_SET, 4'd2, 4'd3, 1'b1);
        send_request(CMD_SET, 4'd3, 4'd15, 1'b1);
        send_request(CMD_SET, 4'd2, 4'd12, 1'b0);
        send_request(CMD_SET, 4'd3, 4'd3, 1'b1);
        send_request(CMD_SET, 4'd5, 4'd2, 1'b1);
        send_request(CMD_SET, 4'd12, 4'd12, 1'b0);
        send_request(CMD_SET, 4'd0, 4'd7, 1'b0);
        send_request(CMD_STATUS, 4'd0, 4'd0, 1'b0);
        send_request(CMD_RESET, 4'd0, 4'd0, 1'b0);

        for (int phase = 0; phase < 4; phase++) begin
            write_mode(phase % 2 == 1);
            send_request(CMD_RESET, 4'd0, 4'd0, 1'b0);
            repeat (RANDOM_PER_PHASE) begin
                if ($urandom_range(0, 29) == 0) wait_for_results();
                random_request();
            end
        end

        wait_for_results();
        if (map_checker.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : out_stall_driver
        forever begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(20, 60)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            i_out_stall <= 1'b1;
            repeat (pick_gap() + 1) @(posedge i_clk);
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            map_checker.check_result({o_frame_valid, o_reset_pulse, o_chip_address, o_data_bit,
                                      o_error_code, o_status_map, o_last});
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/cpx_pkg.sv
rtl/cpx_ctrl.sv
rtl/cpx_datapath.sv
rtl/crosspoint_matrix_controller.sv
bench/tb_crosspoint_matrix_controller.sv
